// ===== rtl/core/afp_pkg.sv =====
package afp_pkg;

  localparam logic [7:0] HdrByte = 8'h55;
  localparam logic [7:0] FrameTypeReset = 8'h53;

  localparam int unsigned NumData = 6;
  localparam int unsigned PosWidth = 4;

  localparam logic [PosWidth-1:0] PosHeader = 4'd0;
  localparam logic [PosWidth-1:0] PosType = 4'd1;
  localparam logic [PosWidth-1:0] PosFirstData = 4'd2;
  localparam logic [PosWidth-1:0] PosLastStored = 4'd7;
  localparam logic [PosWidth-1:0] PosSum = 4'd10;

  localparam logic signed [15:0] AngleMin = -16'sd23040;
  localparam logic signed [15:0] AngleMax = 16'sd23039;

  typedef logic [NumData-1:0][7:0] data_t;

  typedef struct packed {
    logic                frame_ok;
    logic [PosWidth-1:0] pos;
  } hunt_status_t;

endpackage

// ===== rtl/core/afp_scale.sv =====
module afp_scale (
  input  logic [7:0]         lo_i,
  input  logic [7:0]         hi_i,
  output logic signed [15:0] angle_o
);

  logic signed [15:0] raw;
  logic signed [21:0] prod;
  logic signed [21:0] prod_adj;
  logic signed [21:0] quot;

  // The raw value times 45/64, rounded toward zero by biasing negative products.
  assign raw      = $signed({hi_i, lo_i});
  assign prod     = $signed({{6{raw[15]}}, raw}) * 22'sd45;
  assign prod_adj = prod + $signed({16'd0, {6{prod[21]}}});
  assign quot     = prod_adj >>> 6;
  assign angle_o  = quot[15:0];

endmodule

// ===== rtl/core/afp_hunt.sv =====
module afp_hunt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 byte_valid_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [7:0]           frame_type_i,
  output afp_pkg::data_t       data_o,
  output afp_pkg::hunt_status_t status_o
);

  logic [afp_pkg::PosWidth-1:0] pos_q, pos_d;
  logic [7:0]                   sum_q, sum_d;
  afp_pkg::data_t               data_q;
  logic [afp_pkg::PosWidth-1:0] pos_off;
  logic [2:0]                   wr_idx;
  logic                         wr_en;
  logic                         frame_ok;

  assign pos_off = pos_q - afp_pkg::PosFirstData;
  assign wr_idx  = pos_off[2:0];

  always_comb begin
    pos_d    = pos_q;
    sum_d    = sum_q;
    wr_en    = 1'b0;
    frame_ok = 1'b0;
    if (byte_valid_i) begin
      if (pos_q == afp_pkg::PosHeader) begin
        if (rx_byte_i == afp_pkg::HdrByte) begin
          sum_d = afp_pkg::HdrByte;
          pos_d = afp_pkg::PosType;
        end
      end else if (pos_q == afp_pkg::PosType) begin
        if (rx_byte_i == frame_type_i) begin
          sum_d = sum_q + rx_byte_i;
          pos_d = afp_pkg::PosFirstData;
        end else if (rx_byte_i == afp_pkg::HdrByte) begin
          sum_d = afp_pkg::HdrByte;
          pos_d = afp_pkg::PosType;
        end else begin
          pos_d = afp_pkg::PosHeader;
        end
      end else if (pos_q < afp_pkg::PosSum) begin
        wr_en = (pos_q <= afp_pkg::PosLastStored);
        sum_d = sum_q + rx_byte_i;
        pos_d = pos_q + 4'd1;
      end else begin
        pos_d    = afp_pkg::PosHeader;
        frame_ok = (rx_byte_i == sum_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= afp_pkg::PosHeader;
      sum_q <= 8'd0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < afp_pkg::NumData; i++) begin
      if (wr_en && (wr_idx == 3'(i))) begin
        data_q[i] <= rx_byte_i;
      end
    end
  end

  assign data_o            = data_q;
  assign status_o.frame_ok = frame_ok;
  assign status_o.pos      = pos_q;

endmodule

// ===== rtl/core/angle_frame_parser.sv =====
// Hunts a received byte stream for 11-byte angle frames: a 0x55 header, a type
// byte equal to the frame type register (0x53 after reset), eight data bytes and
// a modulo-256 sum of the first ten bytes. Each good frame gives one word of
// roll, pitch and yaw in 1/128 degree, truncated toward zero; frames with a bad
// sum are dropped without notice. One byte is taken every clock cycle, and the
// angle word is registered, appearing in the cycle after its checksum byte is
// accepted. The rate is set by the output register: a byte is refused only
// while a finished word waits in it and the consumer is not ready. Write the
// frame type only while the byte stream is idle.
module angle_frame_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_frame_type_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [15:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o
);

  logic [7:0]            frame_type_q;
  logic                  in_fire;
  afp_pkg::data_t        data;
  afp_pkg::hunt_status_t status;
  logic signed [15:0]    roll_d, pitch_d, yaw_d;
  logic signed [15:0]    roll_q, pitch_q, yaw_q;
  logic                  out_valid_q, out_valid_d;
  logic                  load;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_type_q <= afp_pkg::FrameTypeReset;
    end else if (cfg_valid_i) begin
      frame_type_q <= cfg_frame_type_i;
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  afp_hunt u_hunt (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_fire),
    .rx_byte_i    (rx_byte_i),
    .frame_type_i (frame_type_q),
    .data_o       (data),
    .status_o     (status)
  );

  afp_scale u_scale_roll (
    .lo_i    (data[0]),
    .hi_i    (data[1]),
    .angle_o (roll_d)
  );

  afp_scale u_scale_pitch (
    .lo_i    (data[2]),
    .hi_i    (data[3]),
    .angle_o (pitch_d)
  );

  afp_scale u_scale_yaw (
    .lo_i    (data[4]),
    .hi_i    (data[5]),
    .angle_o (yaw_d)
  );

  assign load = status.frame_ok;

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_ready_o) begin
      out_valid_d = load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      roll_q  <= roll_d;
      pitch_q <= pitch_d;
      yaw_q   <= yaw_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign roll_angle_o  = roll_q;
  assign pitch_angle_o = pitch_q;
  assign yaw_angle_o   = yaw_q;

  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.pos <= afp_pkg::PosSum)
    else $error("frame byte position out of range");

  a_sum_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (status.pos == afp_pkg::PosSum) |=> status.pos == afp_pkg::PosHeader)
    else $error("hunt did not restart after checksum byte");

  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_fire && (status.pos == afp_pkg::PosSum)))
    else $error("angle word without a checksum byte");

  a_angle_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (roll_q >= afp_pkg::AngleMin) && (roll_q <= afp_pkg::AngleMax) &&
                    (pitch_q >= afp_pkg::AngleMin) && (pitch_q <= afp_pkg::AngleMax) &&
                    (yaw_q >= afp_pkg::AngleMin) && (yaw_q <= afp_pkg::AngleMax))
    else $error("angle outside scaled range");

endmodule
